>>> design/rc_pulse_normalizer_with_calibration_macros.svh
// ----------------------------------------------------------------------------
// RC pulse normaliser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_NORMALIZER_WITH_CALIBRATION_MACROS_SVH
`define RC_PULSE_NORMALIZER_WITH_CALIBRATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/rcpn_pkg.sv
// ----------------------------------------------------------------------------
// RC pulse normaliser package
// Field widths, reset calibration values, sequencer states and shared types.
// ----------------------------------------------------------------------------
package rcpn_pkg;

    localparam int unsigned PW_W      = 16;
    localparam int unsigned WIN_W     = 10;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned FRAC_BITS = 14;
    localparam int unsigned CNT_W     = $clog2(FRAC_BITS);

    localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd50;
    localparam logic [VAL_W-1:0] Q_ONE        = 16'd16384;

    localparam logic [PW_W-1:0] CH0_LOW    = 16'd995;
    localparam logic [PW_W-1:0] CH0_CENTER = 16'd1509;
    localparam logic [PW_W-1:0] CH0_HIGH   = 16'd2110;
    localparam logic [PW_W-1:0] CH1_LOW    = 16'd1001;
    localparam logic [PW_W-1:0] CH1_CENTER = 16'd1503;
    localparam logic [PW_W-1:0] CH1_HIGH   = 16'd2080;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_NORM,
        ST_DIVIDE,
        ST_OUTPUT
    } seq_state_t;

    typedef struct packed {
        logic [PW_W-1:0] low;
        logic [PW_W-1:0] center;
        logic [PW_W-1:0] high;
    } cal_triple_t;

    typedef struct packed {
        logic accepted;
        logic calibrating;
        logic done;
    } cal_flags_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> design/rcpn_in_if.sv
// ----------------------------------------------------------------------------
// RC pulse sample channel
// Valid/ready channel carrying one measured pulse and a calibration request.
// ----------------------------------------------------------------------------
interface rcpn_in_if;

    logic                      valid;
    logic                      ready;
    logic                      channel;
    logic [rcpn_pkg::PW_W-1:0] pulse_width;
    logic                      start_calibration;

    modport source (
        output valid,
        output channel,
        output pulse_width,
        output start_calibration,
        input  ready
    );

    modport sink (
        input  valid,
        input  channel,
        input  pulse_width,
        input  start_calibration,
        output ready
    );

endinterface

>>> design/rcpn_out_if.sv
// ----------------------------------------------------------------------------
// RC pulse result channel
// Valid/ready channel carrying the normalised position and calibration state.
// ----------------------------------------------------------------------------
interface rcpn_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [rcpn_pkg::VAL_W-1:0] value;
    logic                              start_accepted;
    logic                              calibrating;
    logic                              cal_done;
    logic        [rcpn_pkg::PW_W-1:0]  low_end;
    logic        [rcpn_pkg::PW_W-1:0]  center;
    logic        [rcpn_pkg::PW_W-1:0]  high_end;

    modport source (
        output valid,
        output value,
        output start_accepted,
        output calibrating,
        output cal_done,
        output low_end,
        output center,
        output high_end,
        input  ready
    );

    modport sink (
        input  valid,
        input  value,
        input  start_accepted,
        input  calibrating,
        input  cal_done,
        input  low_end,
        input  center,
        input  high_end,
        output ready
    );

endinterface

>>> design/rcpn_divider.sv
// ----------------------------------------------------------------------------
// RC pulse normaliser fraction divider
// Restoring divider giving one Q0.14 quotient bit per cycle for num < den.
// ----------------------------------------------------------------------------
module rcpn_divider (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [rcpn_pkg::PW_W-1:0]            num,
    input  logic [rcpn_pkg::PW_W-1:0]            den,
    output logic [rcpn_pkg::FRAC_BITS-1:0]       quotient,
    output rcpn_pkg::div_status_t                status
);

    logic [rcpn_pkg::PW_W-1:0]      rem_reg;
    logic [rcpn_pkg::PW_W-1:0]      den_reg;
    logic [rcpn_pkg::FRAC_BITS-1:0] quo_reg;
    logic [rcpn_pkg::CNT_W-1:0]     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [rcpn_pkg::PW_W:0] shifted;
    logic [rcpn_pkg::PW_W:0] diff;
    logic                    ge;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= rcpn_pkg::CNT_W'(rcpn_pkg::FRAC_BITS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // The remainder stays below the divisor, so it always fits the pulse width.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[rcpn_pkg::PW_W-1:0] : shifted[rcpn_pkg::PW_W-1:0];
            quo_reg <= {quo_reg[rcpn_pkg::FRAC_BITS-2:0], ge};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> design/rcpn_cal_store.sv
// ----------------------------------------------------------------------------
// RC pulse normaliser calibration store
// Per-channel calibration, tracking state and the calibration update step.
// ----------------------------------------------------------------------------
module rcpn_cal_store #(
    parameter int unsigned NUM_CHANNELS = 2,
    parameter int unsigned IDX_W        = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         update,
    input  logic [IDX_W-1:0]             ch_idx,
    input  logic [rcpn_pkg::PW_W-1:0]    pulse,
    input  logic                         start,
    input  logic [rcpn_pkg::WIN_W-1:0]   window,
    output rcpn_pkg::cal_flags_t         flags,
    output rcpn_pkg::cal_triple_t        cal
);

    rcpn_pkg::cal_triple_t          cal_reg [NUM_CHANNELS];
    rcpn_pkg::cal_triple_t          track_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]        in_progress_reg;
    logic [NUM_CHANNELS-1:0]        first_pending_reg;

    rcpn_pkg::cal_triple_t   trk;
    logic [rcpn_pkg::PW_W-1:0] mid;
    logic [rcpn_pkg::PW_W-1:0] win_ext;
    logic [rcpn_pkg::PW_W:0]   hi_thr;
    logic [rcpn_pkg::PW_W-1:0] dev;
    logic                      was_active;
    logic                      accepted;
    logic                      tracking;
    logic                      seeding;
    logic                      widen_hi;
    logic                      widen_lo;
    logic                      finish;
    logic [rcpn_pkg::PW_W-1:0] new_low;
    logic [rcpn_pkg::PW_W-1:0] new_high;

    always_comb
    begin
        trk        = track_reg[ch_idx];
        mid        = trk.center;
        win_ext    = rcpn_pkg::PW_W'(window);
        hi_thr     = {1'b0, mid} + {1'b0, win_ext};
        was_active = in_progress_reg[ch_idx];
        accepted   = start && (pulse != '0);
        tracking   = was_active && !accepted;
        seeding    = tracking && first_pending_reg[ch_idx];
        widen_hi   = ({1'b0, pulse} > hi_thr) && (pulse > trk.high);
        widen_lo   = (mid >= win_ext) && (pulse < (mid - win_ext)) && (pulse < trk.low);
        new_high   = widen_hi ? pulse : trk.high;
        new_low    = widen_lo ? pulse : trk.low;
        dev        = (pulse > mid) ? (pulse - mid) : (mid - pulse);
        finish     = tracking && !seeding && (new_low < mid) && (new_high > mid)
                     && (dev < win_ext);
    end

    always_comb
    begin
        flags.accepted    = accepted;
        flags.done        = finish;
        flags.calibrating = accepted || (was_active && !finish);
        cal               = cal_reg[ch_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (c == 1)
                begin
                    cal_reg[c] <= '{rcpn_pkg::CH1_LOW, rcpn_pkg::CH1_CENTER,
                                    rcpn_pkg::CH1_HIGH};
                end
                else
                begin
                    cal_reg[c] <= '{rcpn_pkg::CH0_LOW, rcpn_pkg::CH0_CENTER,
                                    rcpn_pkg::CH0_HIGH};
                end
            end
            in_progress_reg   <= '0;
            first_pending_reg <= '0;
        end
        else if (update)
        begin
            if (accepted)
            begin
                in_progress_reg[ch_idx]   <= 1'b1;
                first_pending_reg[ch_idx] <= 1'b1;
            end
            else if (seeding)
            begin
                first_pending_reg[ch_idx] <= 1'b0;
            end
            else if (finish)
            begin
                in_progress_reg[ch_idx] <= 1'b0;
                cal_reg[ch_idx]         <= '{new_low, mid, new_high};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && seeding)
        begin
            track_reg[ch_idx] <= '{pulse, pulse, pulse};
        end
        else if (update && tracking)
        begin
            track_reg[ch_idx] <= '{new_low, mid, new_high};
        end
    end

endmodule

>>> design/rc_pulse_normalizer_with_calibration.sv
// ----------------------------------------------------------------------------
// RC pulse normaliser with stick calibration
// Flow: the input transfer is followed by the update and normalise states, then the
// output state for a zero pulse, a zero span or a saturated value, else the divide state.
// One item at a time: the input is ready again only in the cycle after the result
// transfer; the 14-step restoring divider runs in the divide state.
// Reset: calibration returns to its defaults and any calibration is dropped.
// ----------------------------------------------------------------------------
`include "rc_pulse_normalizer_with_calibration_macros.svh"

module rc_pulse_normalizer_with_calibration #(
    parameter int unsigned NUM_CHANNELS = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [rcpn_pkg::WIN_W-1:0]  cfg_wr_data,
    rcpn_in_if.sink                     sample,
    rcpn_out_if.source                  result
);

    localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    rcpn_pkg::seq_state_t state_reg;
    rcpn_pkg::seq_state_t state_next;

    logic [rcpn_pkg::WIN_W-1:0] window_reg;
    logic                       channel_reg;
    logic [rcpn_pkg::PW_W-1:0]  pulse_reg;
    logic                       start_reg;
    logic                       ch_ok_reg;
    logic                       neg_reg;

    logic signed [rcpn_pkg::VAL_W-1:0] value_reg;
    rcpn_pkg::cal_flags_t              flags_reg;
    rcpn_pkg::cal_triple_t             triple_reg;

    logic [IDX_W-1:0]          ch_idx;
    rcpn_pkg::cal_flags_t      flags;
    rcpn_pkg::cal_triple_t     cal;
    logic                      store_update;

    logic                      above;
    logic [rcpn_pkg::PW_W-1:0] num;
    logic [rcpn_pkg::PW_W-1:0] den;
    logic                      span_pos;
    logic                      zero_res;
    logic                      sat_res;
    logic                      div_start;
    logic [rcpn_pkg::FRAC_BITS-1:0] quotient;
    rcpn_pkg::div_status_t     div_stat;
    logic [rcpn_pkg::VAL_W-1:0] mag;

    function automatic logic ch_okay(input logic ch);
        return (32'(ch) < NUM_CHANNELS);
    endfunction

    assign ch_idx = ch_okay(channel_reg) ? IDX_W'(channel_reg) : '0;

    rcpn_cal_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_cal_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (store_update),
        .ch_idx (ch_idx),
        .pulse  (pulse_reg),
        .start  (start_reg),
        .window (window_reg),
        .flags  (flags),
        .cal    (cal)
    );

    rcpn_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num),
        .den      (den),
        .quotient (quotient),
        .status   (div_stat)
    );

    always_comb
    begin
        above    = (pulse_reg > cal.center);
        num      = above ? (pulse_reg - cal.center) : (cal.center - pulse_reg);
        den      = above ? (cal.high - cal.center) : (cal.center - cal.low);
        span_pos = above ? (cal.high > cal.center) : (cal.center > cal.low);
        zero_res = !ch_ok_reg || (pulse_reg == '0) || !span_pos;
        sat_res  = (num >= den);
        mag      = rcpn_pkg::VAL_W'(quotient);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcpn_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = rcpn_pkg::ST_UPDATE;
                end
            end
            rcpn_pkg::ST_UPDATE:
            begin
                state_next = rcpn_pkg::ST_NORM;
            end
            rcpn_pkg::ST_NORM:
            begin
                if (zero_res || sat_res)
                begin
                    state_next = rcpn_pkg::ST_OUTPUT;
                end
                else
                begin
                    state_next = rcpn_pkg::ST_DIVIDE;
                end
            end
            rcpn_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = rcpn_pkg::ST_OUTPUT;
                end
            end
            rcpn_pkg::ST_OUTPUT:
            begin
                if (result.ready)
                begin
                    state_next = rcpn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcpn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sample.ready = (state_reg == rcpn_pkg::ST_IDLE);
        result.valid = (state_reg == rcpn_pkg::ST_OUTPUT);
        store_update = (state_reg == rcpn_pkg::ST_UPDATE) && ch_ok_reg;
        div_start    = (state_reg == rcpn_pkg::ST_NORM) && !zero_res && !sat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rcpn_pkg::ST_IDLE;
            window_reg <= rcpn_pkg::WINDOW_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rcpn_pkg::ST_IDLE:
            begin
                channel_reg <= sample.channel;
                pulse_reg   <= sample.pulse_width;
                start_reg   <= sample.start_calibration;
                ch_ok_reg   <= ch_okay(sample.channel);
            end
            rcpn_pkg::ST_UPDATE:
            begin
                flags_reg <= ch_ok_reg ? flags : '0;
            end
            rcpn_pkg::ST_NORM:
            begin
                triple_reg <= ch_ok_reg ? cal : '0;
                neg_reg    <= !above;
                if (zero_res)
                begin
                    value_reg <= '0;
                end
                else if (sat_res)
                begin
                    value_reg <= above ? signed'(rcpn_pkg::Q_ONE) : -signed'(rcpn_pkg::Q_ONE);
                end
            end
            rcpn_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    value_reg <= neg_reg ? -signed'(mag) : signed'(mag);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign result.value          = value_reg;
    assign result.start_accepted = flags_reg.accepted;
    assign result.calibrating    = flags_reg.calibrating;
    assign result.cal_done       = flags_reg.done;
    assign result.low_end        = triple_reg.low;
    assign result.center         = triple_reg.center;
    assign result.high_end       = triple_reg.high;

    `RCPN_ASSERT_SAME(a_one_item_in_flight, sample.ready, !result.valid, "Input ready while a result is pending.")
    `RCPN_ASSERT_SAME(a_div_done_in_divide, div_stat.done, state_reg == rcpn_pkg::ST_DIVIDE, "Divider finished outside the divide state.")
    `RCPN_ASSERT_NEXT(a_div_starts_busy, div_start, div_stat.busy, "Divider not busy after a start.")
    `RCPN_ASSERT_SAME(a_value_in_range, result.valid, (result.value <= $signed(17'sd16384)) && (result.value >= -$signed(17'sd16384)), "Result outside plus or minus one.")
    `RCPN_ASSERT_SAME(a_done_ends_cal, result.valid && result.cal_done, !result.calibrating && !result.start_accepted, "Completed calibration still armed.")

endmodule
